@@ sv/swiglu_pkg.sv @@
// Shared constants, types and sigmoid table builder for the SwiGLU gate block.
package swiglu_pkg;

	localparam int LANES            = 4;
	localparam int DATA_W           = 16;
	localparam int CNT_W            = 3;
	localparam int FRAC_BITS_DEF    = 10;
	localparam int SIG_SEGMENTS_DEF = 64;
	localparam int SIG_RANGE        = 8;
	localparam int SIG_W            = 17;
	localparam int SILU_W           = 33;
	localparam int MUL_W            = 48;

	localparam logic [SIG_W-1:0] SIG_ONE = 17'h10000;
	localparam logic [SIG_W-1:0] SIG_ZERO = 17'h00000;

	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] count;
	} ctl_t;

	// shift-subtract division, elaboration use only
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-(16*num/den) in Q2.30: Taylor series on num/den, then squared four times
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] z;
		logic [63:0] acc;
		logic [63:0] t;
		z = udiv(num << 30, den);
		acc = 64'd1 << 30;
		t = 64'd1 << 30;
		for (int n = 1; n <= 12; n++) begin
			t = udiv((t * z) >> 30, 64'(n));
			if (n % 2 == 1)
				acc = acc - t;
			else
				acc = acc + t;
		end
		for (int i = 0; i < 4; i++)
			acc = (acc * acc) >> 30;
		return acc;
	endfunction

	// sigmoid(-8 + 16k/segs) in unsigned Q1.16
	function automatic logic [SIG_W-1:0] sig_point(input logic [63:0] k, input logic [63:0] segs);
		logic [63:0] pos;
		logic [63:0] mid;
		logic        neg;
		logic [63:0] num;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] v;
		pos = 64'd16 * k;
		mid = 64'(SIG_RANGE) * segs;
		neg = pos < mid;
		num = neg ? mid - pos : pos - mid;
		e = exp_neg_q30(num, 64'd16 * segs);
		d = (64'd1 << 30) + e;
		v = udiv((64'd1 << 46) + (d >> 1), d);
		return neg ? SIG_W'(64'd65536 - v) : SIG_W'(v);
	endfunction

endpackage

@@ sv/swiglu_lane.sv @@
// One lane: piecewise-linear sigmoid, silu and optional up multiply, five stages.
module swiglu_lane #(
	parameter int FRAC_BITS        = swiglu_pkg::FRAC_BITS_DEF,
	parameter int SIGMOID_SEGMENTS = swiglu_pkg::SIG_SEGMENTS_DEF
) (
	input  logic                                    clk,
	input  logic                                    gated_mode,
	input  logic signed [swiglu_pkg::DATA_W-1:0]    gate,
	input  logic signed [swiglu_pkg::DATA_W-1:0]    up,
	output logic signed [swiglu_pkg::MUL_W-1:0]     mul_s5
);

	localparam int PW  = FRAC_BITS + 4;
	localparam int KW  = $clog2(SIGMOID_SEGMENTS + 1);
	localparam int EW  = ((FRAC_BITS + 5 > 17) ? FRAC_BITS + 5 : 17) + 1;
	localparam int SW  = swiglu_pkg::SIG_W;
	localparam int DW  = swiglu_pkg::DATA_W;
	localparam int LW  = swiglu_pkg::SILU_W;
	localparam int MW  = swiglu_pkg::MUL_W;
	localparam logic signed [EW-1:0] LO = EW'(swiglu_pkg::SIG_RANGE) <<< FRAC_BITS;

	logic [SW-1:0] sig_tab [SIGMOID_SEGMENTS+1];

	for (genvar k = 0; k <= SIGMOID_SEGMENTS; k++) begin : g_tab
		localparam logic [SW-1:0] PT = swiglu_pkg::sig_point(64'(k), 64'(SIGMOID_SEGMENTS));
		assign sig_tab[k] = PT;
	end

	// stage 1: position within the table
	logic signed [EW-1:0] g_ext;
	logic signed [EW-1:0] p_ext;
	logic [PW+KW-1:0]     pos_c;

	assign g_ext = EW'(gate);
	assign p_ext = g_ext + LO;
	assign pos_c = (PW+KW)'(p_ext[PW-1:0]) * (PW+KW)'(SIGMOID_SEGMENTS);

	logic [KW-1:0]         k_s1;
	logic [PW-1:0]         r_s1;
	logic signed [DW-1:0]  g_s1, up_s1;
	logic                  below_s1, above_s1;

	always_ff @(posedge clk) begin
		k_s1     <= pos_c[PW+KW-1:PW];
		r_s1     <= pos_c[PW-1:0];
		g_s1     <= gate;
		up_s1    <= up;
		below_s1 <= g_ext < -LO;
		above_s1 <= g_ext >= LO;
	end

	// stage 2: breakpoint lookup
	logic [SW-1:0]         a_s2, diff_s2;
	logic [PW-1:0]         r_s2;
	logic signed [DW-1:0]  g_s2, up_s2;
	logic                  below_s2, above_s2;

	always_ff @(posedge clk) begin
		a_s2     <= sig_tab[k_s1];
		diff_s2  <= sig_tab[KW'(k_s1 + 1'b1)] - sig_tab[k_s1];
		r_s2     <= r_s1;
		g_s2     <= g_s1;
		up_s2    <= up_s1;
		below_s2 <= below_s1;
		above_s2 <= above_s1;
	end

	// stage 3: slope times remainder
	logic [SW-1:0]         a_s3;
	logic [SW+PW-1:0]      ip_s3;
	logic signed [DW-1:0]  g_s3, up_s3;
	logic                  below_s3, above_s3;

	always_ff @(posedge clk) begin
		a_s3     <= a_s2;
		ip_s3    <= (SW+PW)'(diff_s2) * (SW+PW)'(r_s2);
		g_s3     <= g_s2;
		up_s3    <= up_s2;
		below_s3 <= below_s2;
		above_s3 <= above_s2;
	end

	// stage 4: sigmoid and silu
	logic [SW-1:0]         sig_c;
	logic signed [LW-1:0]  silu_c;

	always_comb begin
		if (below_s3)
			sig_c = swiglu_pkg::SIG_ZERO;
		else if (above_s3)
			sig_c = swiglu_pkg::SIG_ONE;
		else
			sig_c = a_s3 + SW'(ip_s3 >> PW);
	end

	assign silu_c = LW'($signed(g_s3) * $signed({1'b0, sig_c}));

	logic signed [LW-1:0]  silu_s4;
	logic signed [DW-1:0]  up_s4;

	always_ff @(posedge clk) begin
		silu_s4 <= silu_c;
		up_s4   <= up_s3;
	end

	// stage 5: up multiply, or scale plain silu to the same shift
	logic signed [MW-1:0]  prod_c;
	logic signed [MW-1:0]  plain_c;

	assign prod_c  = MW'(silu_s4) * MW'(up_s4);
	assign plain_c = MW'(silu_s4) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		mul_s5 <= gated_mode ? prod_c : plain_c;
	end

endmodule

@@ sv/swiglu_merge.sv @@
// Merge stage: rounds, saturates and masks lane results into the output beat.
module swiglu_merge #(
	parameter int FRAC_BITS = swiglu_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  swiglu_pkg::ctl_t                     ctl_s5,
	input  logic signed [swiglu_pkg::MUL_W-1:0]  mul_s5 [swiglu_pkg::LANES],
	output logic                                 done,
	output logic signed [swiglu_pkg::DATA_W-1:0] res_q [swiglu_pkg::LANES],
	output logic [swiglu_pkg::CNT_W-1:0]         count_q
);

	localparam int MW = swiglu_pkg::MUL_W;
	localparam int DW = swiglu_pkg::DATA_W;
	localparam int SH = FRAC_BITS + 16;
	localparam int RW = MW - SH;
	localparam logic signed [MW-1:0] HALF = MW'(1) <<< (SH - 1);

	logic signed [DW-1:0] res_c [swiglu_pkg::LANES];

	always_comb begin
		for (int i = 0; i < swiglu_pkg::LANES; i++) begin
			logic signed [MW-1:0] t;
			logic signed [RW-1:0] r;
			t = mul_s5[i] + HALF;
			r = RW'(t >>> SH);
			if (r[RW-1:DW-1] != {(RW-DW+1){r[RW-1]}})
				res_c[i] = r[RW-1] ? $signed({1'b1, {(DW-1){1'b0}}})
				                   : $signed({1'b0, {(DW-1){1'b1}}});
			else
				res_c[i] = $signed(r[DW-1:0]);
			if (ctl_s5.count <= swiglu_pkg::CNT_W'(i))
				res_c[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= ctl_s5.valid;
	end

	always_ff @(posedge clk) begin
		res_q   <= res_c;
		count_q <= ctl_s5.count;
	end

endmodule

@@ sv/swiglu_gate_multiply.sv @@
// Top level: four-lane SwiGLU gated multiply with piecewise-linear sigmoid.
// Throughput: one beat per cycle; busy stays low, each lane is a 5-stage pipeline
// followed by the registered merge stage.
// Reset: arst_n clears the control pipeline and done, and sets gated_mode to 1.
// The receiver cannot stall; done marks each result beat for one cycle.
module swiglu_gate_multiply #(
	parameter int FRAC_BITS        = swiglu_pkg::FRAC_BITS_DEF,
	parameter int SIGMOID_SEGMENTS = swiglu_pkg::SIG_SEGMENTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic                                 cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [swiglu_pkg::DATA_W-1:0] gate_0,
	input  logic signed [swiglu_pkg::DATA_W-1:0] gate_1,
	input  logic signed [swiglu_pkg::DATA_W-1:0] gate_2,
	input  logic signed [swiglu_pkg::DATA_W-1:0] gate_3,
	input  logic signed [swiglu_pkg::DATA_W-1:0] up_0,
	input  logic signed [swiglu_pkg::DATA_W-1:0] up_1,
	input  logic signed [swiglu_pkg::DATA_W-1:0] up_2,
	input  logic signed [swiglu_pkg::DATA_W-1:0] up_3,
	input  logic [swiglu_pkg::CNT_W-1:0]         lanes_valid,
	output logic                                 done,
	output logic signed [swiglu_pkg::DATA_W-1:0] out_0,
	output logic signed [swiglu_pkg::DATA_W-1:0] out_1,
	output logic signed [swiglu_pkg::DATA_W-1:0] out_2,
	output logic signed [swiglu_pkg::DATA_W-1:0] out_3,
	output logic [swiglu_pkg::CNT_W-1:0]         lanes_out
);

	localparam int L  = swiglu_pkg::LANES;
	localparam int DW = swiglu_pkg::DATA_W;
	localparam int CW = swiglu_pkg::CNT_W;

	logic accept;
	logic gated_mode_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gated_mode_q <= 1'b1;
		else if (cfg_wen)
			gated_mode_q <= cfg_data;
	end

	// control pipeline alongside the lanes
	swiglu_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.count <= (lanes_valid > CW'(L)) ? CW'(L) : lanes_valid;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	logic signed [DW-1:0]               gate_a [L];
	logic signed [DW-1:0]               up_a   [L];
	logic signed [swiglu_pkg::MUL_W-1:0] mul_s5 [L];
	logic signed [DW-1:0]               res_q  [L];

	assign gate_a[0] = gate_0;
	assign gate_a[1] = gate_1;
	assign gate_a[2] = gate_2;
	assign gate_a[3] = gate_3;
	assign up_a[0]   = up_0;
	assign up_a[1]   = up_1;
	assign up_a[2]   = up_2;
	assign up_a[3]   = up_3;

	for (genvar i = 0; i < L; i++) begin : g_lane
		swiglu_lane #(
			.FRAC_BITS        (FRAC_BITS),
			.SIGMOID_SEGMENTS (SIGMOID_SEGMENTS)
		) u_lane (
			.clk        (clk),
			.gated_mode (gated_mode_q),
			.gate       (gate_a[i]),
			.up         (up_a[i]),
			.mul_s5     (mul_s5[i])
		);
	end

	swiglu_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s5  (ctl_s5),
		.mul_s5  (mul_s5),
		.done    (done),
		.res_q   (res_q),
		.count_q (lanes_out)
	);

	assign out_0 = res_q[0];
	assign out_1 = res_q[1];
	assign out_2 = res_q[2];
	assign out_3 = res_q[3];

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("accepted beat produced no result");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 6))
		else $error("result beat without an accepted input");

	a_count_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> lanes_out <= CW'(L))
		else $error("lane count above lane total");

	a_unused_lane_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && lanes_out < CW'(L)) |-> out_3 == '0)
		else $error("unused top lane not zero");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for swiglu_gate_multiply: random and directed beats, lane predictor.
`timescale 1ns / 1ps

module tb_top;
	import swiglu_pkg::*;

	localparam int FRAC     = FRAC_BITS_DEF;
	localparam int SEGS     = SIG_SEGMENTS_DEF;
	localparam int SPAN     = 16 << FRAC;
	localparam int HALF_RNG = SIG_RANGE << FRAC;
	localparam int PROD_SH  = FRAC + 16;

	typedef struct packed {
		logic [LANES-1:0][DATA_W-1:0] gate;
		logic [LANES-1:0][DATA_W-1:0] up;
		logic [CNT_W-1:0]             cnt;
	} act_beat_t;

	typedef struct packed {
		logic [LANES-1:0][DATA_W-1:0] lane;
		logic [CNT_W-1:0]             cnt;
	} act_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_wen = 1'b0;
	logic                         cfg_data = 1'b0;
	logic                         start = 1'b0;
	logic [LANES-1:0][DATA_W-1:0] gate_bus = '0;
	logic [LANES-1:0][DATA_W-1:0] up_bus = '0;
	logic [CNT_W-1:0]             cnt_bus = '0;
	wire                          busy;
	wire                          done;
	wire signed [DATA_W-1:0]      out_0;
	wire signed [DATA_W-1:0]      out_1;
	wire signed [DATA_W-1:0]      out_2;
	wire signed [DATA_W-1:0]      out_3;
	wire [CNT_W-1:0]              lanes_out;

	act_beat_t   beat_feed_q[$];
	act_result_t act_due_q[$];
	longint      sig_lut [0:SEGS];
	logic        gated_shadow = 1'b1;
	logic        taken = 1'b0;
	int          idle_pct = 0;
	int          n_queued = 0;
	int          n_taken = 0;
	int          n_err = 0;

	swiglu_gate_multiply #(
		.FRAC_BITS(FRAC),
		.SIGMOID_SEGMENTS(SEGS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.gate_0(gate_bus[0]),
		.gate_1(gate_bus[1]),
		.gate_2(gate_bus[2]),
		.gate_3(gate_bus[3]),
		.up_0(up_bus[0]),
		.up_1(up_bus[1]),
		.up_2(up_bus[2]),
		.up_3(up_bus[3]),
		.lanes_valid(cnt_bus),
		.done(done),
		.out_0(out_0),
		.out_1(out_1),
		.out_2(out_2),
		.out_3(out_3),
		.lanes_out(lanes_out)
	);

	always #10 clk = ~clk;

	function automatic longint sigmoid_q16(input logic signed [DATA_W-1:0] g);
		longint gi;
		longint prod;
		longint k;
		longint r;
		gi = longint'(g);
		if (gi < -HALF_RNG)
			return 0;
		if (gi >= HALF_RNG)
			return 65536;
		prod = (gi + HALF_RNG) * SEGS;
		k = prod / SPAN;
		r = prod % SPAN;
		if (k >= SEGS)
			k = SEGS - 1;
		return sig_lut[k] + ((sig_lut[k + 1] - sig_lut[k]) * r) / SPAN;
	endfunction

	function automatic act_result_t predict_activation(input act_beat_t b, input logic gated);
		act_result_t res;
		int          n;
		longint      silu;
		longint      acc;
		res = '0;
		n = (b.cnt > LANES) ? LANES : int'(b.cnt);
		res.cnt = CNT_W'(n);
		for (int i = 0; i < LANES; i++) begin
			if (i < n) begin
				silu = longint'($signed(b.gate[i])) * sigmoid_q16($signed(b.gate[i]));
				if (gated)
					acc = (silu * longint'($signed(b.up[i])) + (longint'(1) << (PROD_SH - 1)))
						>>> PROD_SH;
				else
					acc = (silu + (longint'(1) << 15)) >>> 16;
				if (acc > 32767)
					acc = 32767;
				else if (acc < -32768)
					acc = -32768;
				res.lane[i] = DATA_W'(acc);
			end
		end
		return res;
	endfunction

	function automatic act_beat_t mk_beat(input int g0, input int g1, input int g2, input int g3,
		input int u0, input int u1, input int u2, input int u3, input int cnt);
		act_beat_t b;
		b.gate[0] = DATA_W'(g0);
		b.gate[1] = DATA_W'(g1);
		b.gate[2] = DATA_W'(g2);
		b.gate[3] = DATA_W'(g3);
		b.up[0] = DATA_W'(u0);
		b.up[1] = DATA_W'(u1);
		b.up[2] = DATA_W'(u2);
		b.up[3] = DATA_W'(u3);
		b.cnt = CNT_W'(cnt);
		return b;
	endfunction

	function automatic logic [DATA_W-1:0] rand_gate();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(7))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					3: return DATA_W'(-HALF_RNG);
					4: return DATA_W'(-HALF_RNG - 1);
					5: return DATA_W'(HALF_RNG - 1);
					6: return DATA_W'(HALF_RNG);
					default: return 16'hffff;
				endcase
			end
			1, 2: return DATA_W'($urandom);
			default: return DATA_W'(int'($urandom_range(2 * HALF_RNG + 1600)) - HALF_RNG - 800);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_up();
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(5))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					3: return 16'h0001;
					4: return 16'hffff;
					default: return DATA_W'(1 << FRAC);
				endcase
			end
			1: return DATA_W'($urandom);
			default: return DATA_W'(int'($urandom_range(4096)) - 2048);
		endcase
	endfunction

	task automatic queue_beat(input act_beat_t b);
		beat_feed_q.push_back(b);
		n_queued++;
	endtask

	task automatic queue_directed();
		queue_beat(mk_beat(-32768, 32767, 0, -1, 32767, 32767, -32768, 1, 4));
		queue_beat(mk_beat(-8192, -8193, 8191, 8192, 1024, 1024, 1024, 1024, 4));
		queue_beat(mk_beat(8192, 32767, 8192, 32767, 32767, -32768, -32768, 32767, 4));
		queue_beat(mk_beat(1, -1, 512, -512, -1, -32768, 0, 32767, 3));
		queue_beat(mk_beat(-7936, -256, 0, 256, 1024, 1024, -1024, 1024, 4));
		queue_beat(mk_beat(1000, 2000, 3000, 4000, 5, 5, 5, 5, 0));
		queue_beat(mk_beat(-3000, 3000, -6000, 6000, 2048, -2048, 2048, -2048, 5));
		queue_beat(mk_beat(4096, -4096, 32767, -32768, 32767, 32767, 32767, 32767, 7));
		queue_beat(mk_beat(21845, -21846, 21845, -21846, -21846, 21845, -21846, 21845, 2));
		queue_beat(mk_beat(7000, 8191, -100, 100, -32768, -32768, 32767, 32767, 1));
		queue_beat(mk_beat(-8191, -8000, 8000, 8100, 16384, -16384, 30000, -30000, 6));
		queue_beat(mk_beat(2, 3, -2, -3, 1, 1, 1, 1, 4));
	endtask

	task automatic queue_random(input int n);
		act_beat_t b;
		for (int j = 0; j < n; j++) begin
			for (int i = 0; i < LANES; i++) begin
				b.gate[i] = rand_gate();
				b.up[i] = rand_up();
			end
			b.cnt = CNT_W'($urandom_range(7));
			queue_beat(b);
		end
	endtask

	task automatic settle();
		while (n_taken != n_queued || act_due_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		cfg_data <= m;
		cfg_wen <= 1'b1;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// driver
	always @(negedge clk) begin
		if (!start || taken) begin
			if (beat_feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				act_beat_t b;
				b = beat_feed_q.pop_front();
				gate_bus <= b.gate;
				up_bus <= b.up;
				cnt_bus <= b.cnt;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predicts on accepted beats, checks result beats
	always @(posedge clk) begin
		act_beat_t   b;
		act_result_t want;
		act_result_t got;
		if (arst_n) begin
			if (cfg_wen)
				gated_shadow <= cfg_data;
			if (done) begin
				got.lane = {out_3, out_2, out_1, out_0};
				got.cnt = lanes_out;
				if (act_due_q.size() == 0) begin
					$display("%0t: unexpected result beat, got lanes_out %0d", $time, got.cnt);
					n_err++;
				end else begin
					want = act_due_q.pop_front();
					for (int i = 0; i < LANES; i++) begin
						if (got.lane[i] !== want.lane[i]) begin
							$display("%0t: out_%0d expected %0d got %0d", $time, i,
								$signed(want.lane[i]), $signed(got.lane[i]));
							n_err++;
						end
					end
					if (got.cnt !== want.cnt) begin
						$display("%0t: lanes_out expected %0d got %0d", $time, want.cnt, got.cnt);
						n_err++;
					end
				end
			end
			if (start && !busy) begin
				b.gate = gate_bus;
				b.up = up_bus;
				b.cnt = cnt_bus;
				act_due_q.push_back(predict_activation(b, gated_shadow));
				n_taken <= n_taken + 1;
			end
			taken <= start && !busy;
		end
	end

	initial begin
		longint unsigned pos;
		longint unsigned mid;
		longint unsigned num;
		longint unsigned z;
		longint unsigned acc;
		longint unsigned term;
		longint unsigned den;
		longint unsigned v;
		logic            neg;
		for (int k = 0; k <= SEGS; k++) begin
			pos = 16 * k;
			mid = SIG_RANGE * SEGS;
			neg = pos < mid;
			num = neg ? mid - pos : pos - mid;
			z = (num << 30) / (16 * SEGS);
			acc = 64'd1 << 30;
			term = 64'd1 << 30;
			for (longint unsigned n = 1; n <= 12; n++) begin
				term = ((term * z) >> 30) / n;
				if (n % 2 == 1)
					acc = acc - term;
				else
					acc = acc + term;
			end
			repeat (4) acc = (acc * acc) >> 30;
			den = (64'd1 << 30) + acc;
			v = ((64'd1 << 46) + den / 2) / den;
			sig_lut[k] = neg ? longint'(65536 - v) : longint'(v);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 0;
		queue_directed();
		settle();

		write_mode(1'b0);
		queue_directed();
		queue_random(300);
		settle();

		write_mode(1'b1);
		idle_pct = 73;
		queue_random(300);
		settle();

		idle_pct = 14;
		queue_random(350);
		settle();

		write_mode(1'b0);
		idle_pct = 73;
		queue_random(250);
		settle();

		write_mode(1'b1);
		idle_pct = 0;
		queue_random(350);
		settle();

		write_mode(1'b0);
		idle_pct = 14;
		queue_random(300);
		settle();

		repeat (12) @(posedge clk);
		if (n_err == 0)
			$display("swiglu_gate_multiply verification clean");
		else
			$display("swiglu_gate_multiply verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("swiglu_gate_multiply verification failed");
		$finish;
	end

endmodule

@@ swiglu_gate_multiply.f @@
sv/swiglu_pkg.sv
sv/swiglu_lane.sv
sv/swiglu_merge.sv
sv/swiglu_gate_multiply.sv
test/tb_top.sv
